FILE: rtl/alr_pkg.sv
// Shared types and constants of the antialiased line rasterizer.
package alr_pkg;

    // Fixed field widths
    localparam int IN_W    = 16;
    localparam int PX_W    = 13;
    localparam int BR_W    = 5;
    // Internal widths sized for the widest parameter setting
    localparam int Q_W     = 30;  // coordinate with 16 fraction bits
    localparam int MAJ_W   = 15;  // major-axis pixel column
    localparam int MIN_W   = 31;  // minor coordinate, 16 fraction bits, modular
    localparam int SLOPE_W = 18;  // signed Q2.16
    localparam int GAP_W   = 17;  // Q1.16 coverage
    localparam int CNT_W   = 5;

    localparam logic [GAP_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [15:0]      HALF_Q16 = 16'h8000;
    localparam logic [CNT_W-1:0] DIV_STEPS = 5'd16;

    // Item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic            op;
        logic [IN_W-1:0] start_x;
        logic [IN_W-1:0] start_y;
        logic [IN_W-1:0] end_x;
        logic [IN_W-1:0] end_y;
    } in_t;

    typedef struct packed {
        logic [PX_W-1:0] first_px_x;
        logic [PX_W-1:0] first_px_y;
        logic [BR_W-1:0] first_bright;
        logic [PX_W-1:0] second_px_x;
        logic [PX_W-1:0] second_px_y;
        logic [BR_W-1:0] second_bright;
        logic            last_of_line;
    } out_t;

    // Command passed from the setup side to the pixel side
    typedef struct packed {
        logic                      op;
        logic                      steep;
        logic signed [SLOPE_W-1:0] slope;
        logic [MAJ_W-1:0]          e1;
        logic [MAJ_W-1:0]          e2;
        logic [MIN_W-1:0]          em0;
        logic [MIN_W-1:0]          em1;
        logic [GAP_W-1:0]          eg0;
        logic [GAP_W-1:0]          eg1;
    } cmd_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_ORDER,
        F_PREP,
        F_DIV,
        F_SIGN,
        F_END1,
        F_END2,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_INNER
    } phase_t;

endpackage

FILE: rtl/antialiased_line_rasterizer.sv
// Top level of the antialiased line rasterizer.
// Wu-style antialiased line walker. A load item (op 0) occupies the setup side
// from its transfer to the next input transfer: endpoint ordering, a 17-step
// restoring divide for the slope, two endpoint multiplies and a push into a
// two-entry command queue. A pixel request (op 1) goes straight into the queue
// while the setup side is idle and the queue has room; the pixel side retires
// one request per clock unless its output stalls, through a selection stage and
// an output register, so a steady unstalled stream yields one pair per clock.
module antialiased_line_rasterizer import alr_pkg::*; #(
    parameter int COORD_INT_BITS  = 12,
    parameter int COORD_FRAC_BITS = 4,
    parameter int BRIGHT_BITS     = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic q_push, q_full, q_pop, q_valid;
    cmd_t q_in, q_head;

    alr_front #(
        .COORD_INT_BITS (COORD_INT_BITS),
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_front (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .q_push (q_push),
        .q_cmd  (q_in),
        .q_full (q_full)
    );

    alr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head_valid(q_valid),
        .head_cmd  (q_head)
    );

    alr_back #(
        .COORD_INT_BITS(COORD_INT_BITS),
        .BRIGHT_BITS   (BRIGHT_BITS)
    ) u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .q_valid(q_valid),
        .q_cmd  (q_head),
        .q_pop  (q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

endmodule

FILE: rtl/alr_front.sv
// Input side: accepts items, runs line setup (ordering, slope divide, endpoints).
module alr_front import alr_pkg::*; #(
    parameter int COORD_INT_BITS  = 12,
    parameter int COORD_FRAC_BITS = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic q_push,
    output cmd_t q_cmd,
    input  logic q_full
);

    localparam int CB = COORD_INT_BITS + COORD_FRAC_BITS;
    localparam int SC = 16 - COORD_FRAC_BITS;
    localparam logic [IN_W-1:0] CMASK =
        (CB >= IN_W) ? {IN_W{1'b1}} : IN_W'((32'd1 << CB) - 32'd1);

    front_state_t state_reg, state_next;
    logic [Q_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [Q_W-1:0] ax_next, ay_next, bx_next, by_next;
    logic steep_reg, steep_next;
    logic [Q_W-1:0] dx_reg, dx_next;
    logic neg_reg, neg_next;
    logic [Q_W:0] rem_reg, rem_next;
    logic [16:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic signed [SLOPE_W-1:0] slope_reg, slope_next;
    logic signed [35:0] prod_reg, prod_next;
    logic [MIN_W-1:0] em0_reg, em0_next;

    logic [Q_W-1:0] sx, sy, ex, ey;
    logic [Q_W:0] adx, ady;
    logic is_steep;
    logic [Q_W-1:0] pax, pay, pbx, pby;
    logic signed [Q_W:0] dy_s;
    logic qbit;
    logic [Q_W:0] rem_sub;
    logic [Q_W:0] r1, r2;
    logic signed [SLOPE_W-1:0] d1, d2;
    logic [MIN_W-1:0] em1;
    logic [MIN_W-1:0] prod_ext;

    function automatic logic [Q_W-1:0] scale_coord(input logic [IN_W-1:0] v);
        logic [31:0] w;
        w = 32'(v & CMASK) << SC;
        return Q_W'(w);
    endfunction

    assign sx = scale_coord(s_data.start_x);
    assign sy = scale_coord(s_data.start_y);
    assign ex = scale_coord(s_data.end_x);
    assign ey = scale_coord(s_data.end_y);

    // Endpoint rounding terms
    assign r1 = {1'b0, ax_reg} + {{(Q_W-15){1'b0}}, HALF_Q16};
    assign r2 = {1'b0, bx_reg} + {{(Q_W-15){1'b0}}, HALF_Q16};
    assign d1 = $signed({2'b00, HALF_Q16}) - $signed({2'b00, r1[15:0]});
    assign d2 = $signed({2'b00, HALF_Q16}) - $signed({2'b00, r2[15:0]});
    assign prod_ext = MIN_W'(prod_reg >>> 16);
    assign em1 = {1'b0, by_reg} + prod_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        bx_reg    <= bx_next;
        by_reg    <= by_next;
        steep_reg <= steep_next;
        dx_reg    <= dx_next;
        neg_reg   <= neg_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        slope_reg <= slope_next;
        prod_reg  <= prod_next;
        em0_reg   <= em0_next;
    end

    // Setup sequencer
    always_comb begin
        state_next = state_reg;
        ax_next = ax_reg;
        ay_next = ay_reg;
        bx_next = bx_reg;
        by_next = by_reg;
        steep_next = steep_reg;
        dx_next = dx_reg;
        neg_next = neg_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        slope_next = slope_reg;
        prod_next = prod_reg;
        em0_next = em0_reg;
        s_ready = 1'b0;
        q_push = 1'b0;
        q_cmd = '0;
        q_cmd.op = OP_STEP;

        adx = (bx_reg > ax_reg) ? {1'b0, bx_reg - ax_reg} : {1'b0, ax_reg - bx_reg};
        ady = (by_reg > ay_reg) ? {1'b0, by_reg - ay_reg} : {1'b0, ay_reg - by_reg};
        is_steep = ady > adx;
        pax = is_steep ? ay_reg : ax_reg;
        pay = is_steep ? ax_reg : ay_reg;
        pbx = is_steep ? by_reg : bx_reg;
        pby = is_steep ? bx_reg : by_reg;
        dy_s = $signed({1'b0, by_reg}) - $signed({1'b0, ay_reg});
        qbit = rem_reg >= {1'b0, dx_reg};
        rem_sub = qbit ? rem_reg - {1'b0, dx_reg} : rem_reg;

        case (state_reg)
            F_IDLE: begin
                s_ready = !q_full;
                if (s_valid && !q_full) begin
                    if (s_data.op == OP_LOAD) begin
                        ax_next = sx;
                        ay_next = sy;
                        bx_next = ex;
                        by_next = ey;
                        state_next = F_ORDER;
                    end else begin
                        q_push = 1'b1;
                    end
                end
            end
            F_ORDER: begin
                steep_next = is_steep;
                if (pax > pbx) begin
                    ax_next = pbx;
                    ay_next = pby;
                    bx_next = pax;
                    by_next = pay;
                end else begin
                    ax_next = pax;
                    ay_next = pay;
                    bx_next = pbx;
                    by_next = pby;
                end
                state_next = F_PREP;
            end
            F_PREP: begin
                dx_next = bx_reg - ax_reg;
                neg_next = dy_s < 0;
                rem_next = (dy_s < 0) ? (Q_W+1)'(-dy_s) : (Q_W+1)'(dy_s);
                quo_next = '0;
                cnt_next = DIV_STEPS;
                state_next = F_DIV;
            end
            // One quotient bit per cycle, MSB first
            F_DIV: begin
                quo_next = {quo_reg[15:0], qbit};
                rem_next = {rem_sub[Q_W-1:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = F_SIGN;
                end
            end
            F_SIGN: begin
                if (dx_reg == '0) begin
                    slope_next = $signed({1'b0, ONE_Q16});
                end else if (neg_reg) begin
                    slope_next = -$signed({1'b0, quo_reg});
                end else begin
                    slope_next = $signed({1'b0, quo_reg});
                end
                state_next = F_END1;
            end
            F_END1: begin
                prod_next = 36'(slope_reg * d1);
                state_next = F_END2;
            end
            F_END2: begin
                em0_next = {1'b0, ay_reg} + prod_ext;
                prod_next = 36'(slope_reg * d2);
                state_next = F_PUSH;
            end
            F_PUSH: begin
                q_cmd.op = OP_LOAD;
                q_cmd.steep = steep_reg;
                q_cmd.slope = slope_reg;
                q_cmd.e1 = r1[16 +: MAJ_W];
                q_cmd.e2 = r2[16 +: MAJ_W];
                q_cmd.em0 = em0_reg;
                q_cmd.em1 = em1;
                q_cmd.eg0 = ONE_Q16 - {1'b0, r1[15:0]};
                q_cmd.eg1 = {1'b0, r2[15:0]};
                if (!q_full) begin
                    q_push = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/alr_queue.sv
// Two-entry command queue between the setup and pixel sides.
module alr_queue import alr_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t entry_reg [2];
    logic wr_ptr_reg, wr_ptr_next;
    logic rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_cmd = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/alr_back.sv
// Pixel side: holds the active line, walks it and forms brightness pairs.
module alr_back import alr_pkg::*; #(
    parameter int COORD_INT_BITS = 12,
    parameter int BRIGHT_BITS    = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    input  cmd_t q_cmd,
    output logic q_pop,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int BR_SH = 32 - BRIGHT_BITS;
    localparam logic [MAJ_W-1:0] PXM = MAJ_W'((32'd1 << (COORD_INT_BITS + 1)) - 32'd1);

    // Line state
    logic active_reg, active_next;
    logic steep_reg, steep_next;
    phase_t phase_reg, phase_next;
    logic [MAJ_W-1:0] mpos_reg, mpos_next, mstop_reg, mstop_next;
    logic [MIN_W-1:0] icpt_reg, icpt_next;
    logic signed [SLOPE_W-1:0] slope_reg, slope_next;
    logic [MIN_W-1:0] em0_reg, em0_next, em1_reg, em1_next;
    logic [GAP_W-1:0] eg0_reg, eg0_next, eg1_reg, eg1_next;

    // Selection stage
    logic a_valid_reg, a_valid_next;
    logic [MIN_W-1:0] a_minor_reg, a_minor_next;
    logic [MAJ_W-1:0] a_major_reg, a_major_next;
    logic [GAP_W-1:0] a_gap_reg, a_gap_next;
    logic a_steep_reg, a_steep_next, a_last_reg, a_last_next;

    // Output register
    logic m_valid_reg, m_valid_next;
    out_t m_data_reg, m_data_next;

    logic b_take, a_take, step_go;
    logic [MAJ_W-1:0] mpos_inc;
    logic [15:0] fr;
    logic [32:0] p1, p2;
    logic [MAJ_W-1:0] whole, mn1, mn2, mj;

    assign b_take = !m_valid_reg || m_ready;
    assign a_take = !a_valid_reg || b_take;
    assign step_go = q_valid && (q_cmd.op == OP_STEP) && active_reg && a_take;
    assign mpos_inc = mpos_reg + 1'b1;
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    // Command handling and pair selection
    always_comb begin
        active_next = active_reg;
        steep_next = steep_reg;
        phase_next = phase_reg;
        mpos_next = mpos_reg;
        mstop_next = mstop_reg;
        icpt_next = icpt_reg;
        slope_next = slope_reg;
        em0_next = em0_reg;
        em1_next = em1_reg;
        eg0_next = eg0_reg;
        eg1_next = eg1_reg;
        a_valid_next = a_take ? 1'b0 : a_valid_reg;
        a_minor_next = a_minor_reg;
        a_major_next = a_major_reg;
        a_gap_next = a_gap_reg;
        a_steep_next = a_steep_reg;
        a_last_next = a_last_reg;
        q_pop = 1'b0;

        if (q_valid && q_cmd.op == OP_LOAD) begin
            q_pop = 1'b1;
            active_next = 1'b1;
            steep_next = q_cmd.steep;
            phase_next = PH_FIRST;
            mpos_next = q_cmd.e1;
            mstop_next = q_cmd.e2;
            icpt_next = q_cmd.em0 + MIN_W'(q_cmd.slope);
            slope_next = q_cmd.slope;
            em0_next = q_cmd.em0;
            em1_next = q_cmd.em1;
            eg0_next = q_cmd.eg0;
            eg1_next = q_cmd.eg1;
        end else if (q_valid && !active_reg) begin
            // Request with no line: dropped
            q_pop = 1'b1;
        end else if (step_go) begin
            q_pop = 1'b1;
            a_valid_next = 1'b1;
            a_steep_next = steep_reg;
            a_last_next = 1'b0;
            case (phase_reg)
                PH_FIRST: begin
                    a_minor_next = em0_reg;
                    a_major_next = mpos_reg;
                    a_gap_next = eg0_reg;
                    phase_next = PH_SECOND;
                end
                PH_SECOND: begin
                    a_minor_next = em1_reg;
                    a_major_next = mstop_reg;
                    a_gap_next = eg1_reg;
                    mpos_next = mpos_inc;
                    if (mpos_inc < mstop_reg) begin
                        phase_next = PH_INNER;
                    end else begin
                        a_last_next = 1'b1;
                        active_next = 1'b0;
                    end
                end
                default: begin
                    a_minor_next = icpt_reg;
                    a_major_next = mpos_reg;
                    a_gap_next = ONE_Q16;
                    icpt_next = icpt_reg + MIN_W'(slope_reg);
                    mpos_next = mpos_inc;
                    if (!(mpos_inc < mstop_reg)) begin
                        a_last_next = 1'b1;
                        active_next = 1'b0;
                    end
                end
            endcase
        end
    end

    // Brightness and pixel coordinates
    always_comb begin
        fr = a_minor_reg[15:0];
        p2 = {17'b0, fr} * {16'b0, a_gap_reg};
        p1 = {a_gap_reg, 16'b0} - p2;
        whole = a_minor_reg[MIN_W-1:16];
        mn1 = whole & PXM;
        mn2 = (whole + 1'b1) & PXM;
        mj = a_major_reg & PXM;
        m_valid_next = b_take ? a_valid_reg : m_valid_reg;
        m_data_next = m_data_reg;
        if (b_take && a_valid_reg) begin
            m_data_next.first_bright  = BR_W'(p1 >> BR_SH);
            m_data_next.second_bright = BR_W'(p2 >> BR_SH);
            m_data_next.last_of_line  = a_last_reg;
            if (a_steep_reg) begin
                m_data_next.first_px_x  = PX_W'(mn1);
                m_data_next.first_px_y  = PX_W'(mj);
                m_data_next.second_px_x = PX_W'(mn2);
                m_data_next.second_px_y = PX_W'(mj);
            end else begin
                m_data_next.first_px_x  = PX_W'(mj);
                m_data_next.first_px_y  = PX_W'(mn1);
                m_data_next.second_px_x = PX_W'(mj);
                m_data_next.second_px_y = PX_W'(mn2);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            phase_reg   <= PH_FIRST;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            phase_reg   <= phase_next;
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
        steep_reg   <= steep_next;
        mpos_reg    <= mpos_next;
        mstop_reg   <= mstop_next;
        icpt_reg    <= icpt_next;
        slope_reg   <= slope_next;
        em0_reg     <= em0_next;
        em1_reg     <= em1_next;
        eg0_reg     <= eg0_next;
        eg1_reg     <= eg1_next;
        a_minor_reg <= a_minor_next;
        a_major_reg <= a_major_next;
        a_gap_reg   <= a_gap_next;
        a_steep_reg <= a_steep_next;
        a_last_reg  <= a_last_next;
        m_data_reg  <= m_data_next;
    end

endmodule

FILE: rtl/alr_checker.sv
// Port-level checks for the antialiased line rasterizer, bound to the top level.
module alr_checker import alr_pkg::*; #(
    parameter int COORD_INT_BITS = 12,
    parameter int BRIGHT_BITS    = 4
) (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_data,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    localparam logic [PX_W-1:0] PXM = PX_W'((32'd1 << (COORD_INT_BITS + 1)) - 32'd1);
    localparam logic [5:0] BR_MAX = 6'(32'd1 << BRIGHT_BITS);

    // A stalled transfer holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // No result straight out of reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Two pixels of a pair are neighbors on one axis
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            (m_data.second_px_x == m_data.first_px_x &&
             m_data.second_px_y == ((m_data.first_px_y + 1'b1) & PXM)) ||
            (m_data.second_px_y == m_data.first_px_y &&
             m_data.second_px_x == ((m_data.first_px_x + 1'b1) & PXM)))
        else $error("pair pixels not adjacent");

    // Truncated coverage of a pair never exceeds full brightness (checked for BRIGHT_BITS up to 4)
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && BRIGHT_BITS <= 4 |->
            ({1'b0, m_data.first_bright} + {1'b0, m_data.second_bright}) <= BR_MAX)
        else $error("pair brightness too high");

endmodule

bind antialiased_line_rasterizer alr_checker #(
    .COORD_INT_BITS(COORD_INT_BITS),
    .BRIGHT_BITS   (BRIGHT_BITS)
) u_alr_checker (.*);
